[src/pnic_pkg.sv]
// Package for the packet network interface core: item structs, codes,
// status bit positions and the ones' complement adder. No dependencies.
`default_nettype none
package pnic_pkg;

   localparam int RxDepthDefault = 256;
   localparam int TxDataDefault  = 126;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_RXWRD = 2'd2;
   localparam logic [1:0] ACT_PULL  = 2'd3;

   localparam logic [2:0] REG_STATUS = 3'd0;
   localparam logic [2:0] REG_ADDR   = 3'd1;
   localparam logic [2:0] REG_RDBUF  = 3'd2;
   localparam logic [2:0] REG_BITCNT = 3'd3;
   localparam logic [2:0] REG_SPARE4 = 3'd4;
   localparam logic [2:0] REG_START  = 3'd5;
   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;

   localparam logic [15:0] ST_CMD_MASK  = 16'o000067;
   localparam logic [15:0] ST_KEEP_MASK = 16'o160367;
   localparam logic [15:0] ST_RXIE      = 16'o000020;
   localparam logic [15:0] ST_TXIE      = 16'o000040;
   localparam logic [15:0] ST_TXA       = 16'o000100;
   localparam logic [15:0] ST_TXD       = 16'o000200;
   localparam logic [15:0] ST_CRC       = 16'o040000;
   localparam logic [15:0] ST_RXD       = 16'o100000;
   localparam logic [15:0] CMD_CRX      = 16'o000010;
   localparam logic [15:0] CMD_CTX      = 16'o000400;
   localparam logic [15:0] CMD_RESET    = 16'o020000;
   localparam logic [15:0] BITCNT_MASK  = 16'o007777;
   localparam logic [15:0] SUM_GOOD     = 16'hffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  reg_index;
      logic [15:0] data_word;
      logic        end_of_packet;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
      logic [15:0] tx_word;
      logic        tx_valid;
      logic        tx_last;
   } rsp_type;

   // end-around carry add
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage
`default_nettype wire

[src/pnic_tx_buf.sv]
// Transmit word buffer: one write port, one registered read port.
// Depends on pnic_pkg for the default depth.
`default_nettype none
module pnic_tx_buf
   import pnic_pkg::*;
#(
   parameter int TX_DATA_WORDS = TxDataDefault
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TX_DATA_WORDS)-1:0] wr_addr,
   input  wire logic [15:0]                      wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(TX_DATA_WORDS)-1:0] rd_addr,
   output logic [15:0]                           rd_data
);

   logic [15:0] mem [TX_DATA_WORDS];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/packet_nic_register_model_core.sv]
// Top level of the packet network interface core: register bank, receive
// buffer and checksum, transmit control. Uses pnic_pkg and pnic_tx_buf.
//
// Usage: the req channel carries one item per access: a bus read, a bus
// write, a received payload word or a link pull. Every item gives exactly
// one rsp item (read data, irq, pulled transmit word and its flags).
// The node address is written through csr_wr_en/csr_wr_data.
// The result of an accepted item is registered and shows on rsp from the
// next cycle. Throughput is one item per cycle while rsp is not stalled;
// all work is done between the request edge and the result register, with
// the receive and transmit buffers each read at most once per item through
// registered ports. When rsp is stalled the result holds, and req_stall is
// high while it waits, so no item is taken until it leaves.
// Synchronous reset clears all control state and the node address; the
// buffers are not cleared and are only read where written.
`default_nettype none
module packet_nic_register_model_core
   import pnic_pkg::*;
#(
   parameter int RX_DEPTH_WORDS = RxDepthDefault,
   parameter int TX_DATA_WORDS  = TxDataDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int RW = $clog2(RX_DEPTH_WORDS + 1);
   localparam int RA = $clog2(RX_DEPTH_WORDS);
   localparam int TW = $clog2(TX_DATA_WORDS + 1);
   localparam int TA = $clog2(TX_DATA_WORDS);

   logic [15:0]   node_ff;
   logic [15:0]   status_ff, status_in;
   logic [3:0]    lost_ff, lost_in;
   logic [RW-1:0] rtot_ff, rtot_in;
   logic [RW-1:0] rleft_ff, rleft_in;
   logic [15:0]   rsum_ff, rsum_in;
   logic          rin_ff, rin_in;
   logic          rdrop_ff, rdrop_in;
   logic [TW-1:0] tw_ff, tw_in;
   logic [15:0]   tsum_ff, tsum_in;
   logic          tpend_ff, tpend_in;
   logic [TW-1:0] tpull_ff, tpull_in;
   logic          ckwr_ff, ckwr_in;
   logic [TA-1:0] ckaddr_ff, ckaddr_in;
   logic [15:0]   ckdata_ff, ckdata_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rd_ff, rd_in;
   logic          irq_ff, irq_in;
   logic          txv_ff, txv_in;
   logic          txl_ff, txl_in;
   logic          selrx_ff, selrx_in;
   logic          seltx_ff, seltx_in;
   logic [15:0]   rx_q_ff;

   logic [15:0]   rx_mem [RX_DEPTH_WORDS];
   logic          rx_we;
   logic [RA-1:0] rx_waddr;
   logic [RA-1:0] rx_raddr;
   logic          tx_we;
   logic [TA-1:0] tx_waddr;
   logic [15:0]   tx_wdata;
   logic          buf_we;
   logic [TA-1:0] buf_waddr;
   logic [15:0]   buf_wdata;
   logic [TA-1:0] tx_raddr;
   logic [15:0]   tx_q;
   logic          accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      logic [15:0]   s1;
      logic [15:0]   d;
      logic [RW-1:0] diff;
      status_in = status_ff;
      lost_in   = lost_ff;
      rtot_in   = rtot_ff;
      rleft_in  = rleft_ff;
      rsum_in   = rsum_ff;
      rin_in    = rin_ff;
      rdrop_in  = rdrop_ff;
      tw_in     = tw_ff;
      tsum_in   = tsum_ff;
      tpend_in  = tpend_ff;
      tpull_in  = tpull_ff;
      ckwr_in   = 1'b0;
      ckaddr_in = ckaddr_ff;
      ckdata_in = ckdata_ff;
      rd_in     = 16'd0;
      txv_in    = 1'b0;
      txl_in    = 1'b0;
      selrx_in  = 1'b0;
      seltx_in  = 1'b0;
      rx_we     = 1'b0;
      rx_waddr  = rtot_ff[RA-1:0];
      tx_we     = 1'b0;
      tx_waddr  = tw_ff[TA-1:0];
      tx_wdata  = req_data.data_word;
      tx_raddr  = tpull_ff[TA-1:0];
      s1        = 16'd0;
      d         = req_data.data_word;
      diff      = rtot_ff - rleft_ff;
      rx_raddr  = diff[RA-1:0];
      if (accept) begin
         unique case (req_data.action)
            ACT_READ: begin
               unique case (req_data.reg_index)
                  REG_STATUS: rd_in = (status_ff & ST_KEEP_MASK) | {3'd0, lost_ff, 9'd0};
                  REG_ADDR:   rd_in = node_ff;
                  REG_RDBUF: begin
                     if (rleft_ff != '0) begin
                        selrx_in = 1'b1;
                        rleft_in = rleft_ff - 1'b1;
                     end
                  end
                  REG_BITCNT: rd_in = (16'({rleft_ff, 4'h0}) - 16'd1) & BITCNT_MASK;
                  REG_START: begin
                     rd_in = node_ff;
                     if (!tpend_ff && tw_ff < TW'(TX_DATA_WORDS)) begin
                        tx_we     = 1'b1;
                        tx_wdata  = node_ff;
                        s1        = oc_add(tsum_ff, node_ff);
                        tw_in     = tw_ff + 1'b1;
                        tsum_in   = s1;
                        status_in = status_in & ~ST_TXD;
                        if (({1'b0, tw_ff} + 1'b1) < (TW + 1)'(TX_DATA_WORDS)) begin
                           ckwr_in   = 1'b1;
                           ckaddr_in = TA'(tw_ff + 1'b1);
                           ckdata_in = ~s1;
                           tw_in     = tw_ff + TW'(2);
                           tsum_in   = oc_add(s1, ~s1);
                           tpend_in  = 1'b1;
                           tpull_in  = '0;
                           status_in = status_in | ST_TXD;
                        end
                     end
                  end
                  default: rd_in = 16'd0;
               endcase
            end
            ACT_WRITE: begin
               if (req_data.reg_index == REG_STATUS) begin
                  if ((d & CMD_RESET) != 16'd0) begin
                     status_in = 16'd0;
                     lost_in   = 4'd0;
                     rtot_in   = '0;
                     rleft_in  = '0;
                     rsum_in   = 16'd0;
                     rin_in    = 1'b0;
                     rdrop_in  = 1'b0;
                     tw_in     = '0;
                     tsum_in   = 16'd0;
                     tpend_in  = 1'b0;
                     tpull_in  = '0;
                  end
                  if ((d & CMD_CRX) != 16'd0) begin
                     rleft_in  = '0;
                     status_in = status_in & ~(ST_RXD | ST_CRC);
                     lost_in   = 4'd0;
                  end
                  if ((d & CMD_CTX) != 16'd0) begin
                     tw_in     = '0;
                     tsum_in   = 16'd0;
                     tpend_in  = 1'b0;
                     tpull_in  = '0;
                     status_in = (status_in | ST_TXD) & ~ST_TXA;
                  end
                  status_in = (status_in & ~ST_CMD_MASK) | (d & ST_CMD_MASK);
               end else if (req_data.reg_index == REG_ADDR) begin
                  if (!tpend_ff && tw_ff < TW'(TX_DATA_WORDS)) begin
                     tx_we     = 1'b1;
                     tw_in     = tw_ff + 1'b1;
                     tsum_in   = oc_add(tsum_ff, d);
                     status_in = status_ff & ~ST_TXD;
                  end
               end
            end
            ACT_RXWRD: begin
               if (!rin_ff) begin
                  rin_in = 1'b1;
                  if ((status_ff & ST_RXD) != 16'd0) begin
                     rdrop_in = 1'b1;
                     lost_in  = lost_ff + 4'd1;
                  end else begin
                     rdrop_in = 1'b0;
                     rtot_in  = '0;
                     rsum_in  = 16'd0;
                  end
               end
               rx_waddr = rtot_in[RA-1:0];
               if (!rdrop_in && rtot_in < RW'(RX_DEPTH_WORDS)) begin
                  rx_we   = 1'b1;
                  rtot_in = rtot_in + 1'b1;
                  rsum_in = oc_add(rsum_in, d);
               end
               if (req_data.end_of_packet) begin
                  if (!rdrop_in) begin
                     rleft_in = rtot_in;
                     if (rsum_in != SUM_GOOD) begin
                        status_in = status_in | ST_CRC;
                     end
                     status_in = status_in | ST_RXD;
                  end
                  rin_in   = 1'b0;
                  rdrop_in = 1'b0;
               end
            end
            default: begin
               if (tpend_ff && tpull_ff < tw_ff) begin
                  seltx_in = 1'b1;
                  txv_in   = 1'b1;
                  tpull_in = tpull_ff + 1'b1;
                  if (tpull_in >= tw_ff) begin
                     txl_in   = 1'b1;
                     tpend_in = 1'b0;
                  end
               end else begin
                  tpend_in = 1'b0;
               end
            end
         endcase
      end
      irq_in = ((status_in & (ST_RXD | ST_RXIE)) == (ST_RXD | ST_RXIE)) ||
               ((status_in & (ST_TXD | ST_TXIE)) == (ST_TXD | ST_TXIE));
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   // checksum word goes in the cycle after a start; no append can use the port then
   assign buf_we    = tx_we | ckwr_ff;
   assign buf_waddr = ckwr_ff ? ckaddr_ff : tx_waddr;
   assign buf_wdata = ckwr_ff ? ckdata_ff : tx_wdata;

   pnic_tx_buf #(
      .TX_DATA_WORDS(TX_DATA_WORDS)
   ) u_tx_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (seltx_in),
      .rd_addr (tx_raddr),
      .rd_data (tx_q)
   );

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_waddr] <= req_data.data_word;
      end
      if (selrx_in) begin
         rx_q_ff <= rx_mem[rx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= 16'd0;
         status_ff    <= 16'd0;
         lost_ff      <= 4'd0;
         rtot_ff      <= '0;
         rleft_ff     <= '0;
         rsum_ff      <= 16'd0;
         rin_ff       <= 1'b0;
         rdrop_ff     <= 1'b0;
         tw_ff        <= '0;
         tsum_ff      <= 16'd0;
         tpend_ff     <= 1'b0;
         tpull_ff     <= '0;
         ckwr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_ff <= csr_wr_data;
         end
         status_ff    <= status_in;
         lost_ff      <= lost_in;
         rtot_ff      <= rtot_in;
         rleft_ff     <= rleft_in;
         rsum_ff      <= rsum_in;
         rin_ff       <= rin_in;
         rdrop_ff     <= rdrop_in;
         tw_ff        <= tw_in;
         tsum_ff      <= tsum_in;
         tpend_ff     <= tpend_in;
         tpull_ff     <= tpull_in;
         ckwr_ff      <= ckwr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ckaddr_ff <= ckaddr_in;
      ckdata_ff <= ckdata_in;
      if (accept) begin
         rd_ff    <= rd_in;
         irq_ff   <= irq_in;
         txv_ff   <= txv_in;
         txl_ff   <= txl_in;
         selrx_ff <= selrx_in;
         seltx_ff <= seltx_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.read_data = selrx_ff ? rx_q_ff : rd_ff;
   assign rsp_data.irq       = irq_ff;
   assign rsp_data.tx_word   = seltx_ff ? tx_q : 16'd0;
   assign rsp_data.tx_valid  = txv_ff;
   assign rsp_data.tx_last   = txl_ff;

endmodule
`default_nettype wire
